// File: rtl/core/lcr_pkg.sv
// shared types, opcodes and helpers of the shape rasterizer
package lcr_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_LINE   = 2'd1,
    FUNC_CIRCLE = 2'd2,
    FUNC_RECT   = 2'd3
  } func_e;

  localparam int WORD_W         = 32;
  localparam int WORDS_PER_ITEM = 4;
  localparam int IDX_W          = 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS_PER_ITEM - 1);

  localparam int ARC_W     = 10;
  localparam int ARC_ERR_W = 12;
  localparam int SPAN_W    = 2;
  localparam logic [SPAN_W-1:0] SPAN_LAST = 2'd3;

  localparam logic [7:0]  OP_COL_WIN = 8'h2A;
  localparam logic [7:0]  OP_ROW_WIN = 8'h2B;
  localparam logic [7:0]  OP_STREAM  = 8'h2C;
  localparam logic [23:0] STREAM_ONE = 24'd1;

  typedef struct packed {
    logic [WORDS_PER_ITEM-1:0][WORD_W-1:0] words;
    logic                                  done;
    logic                                  busy;
  } record_t;

  function automatic logic [WORD_W-1:0] window_word(logic [7:0] op, logic [7:0] a,
                                                    logic [7:0] b);
    return {op, a, b, 8'h00};
  endfunction

endpackage

// File: rtl/core/lcr_if.sv
// valid/ready channels for shape commands and display words
interface lcr_in_if #(parameter int COORD_BITS = 10);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [31:0]                  color;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [7:0]                   radius;
  logic [7:0]                   width;
  logic [7:0]                   height;

  modport source (output valid, func, color, x_start, y_start, x_end, y_end, radius, width,
                  height, input ready);
  modport sink   (input valid, func, color, x_start, y_start, x_end, y_end, radius, width,
                  height, output ready);
endinterface

interface lcr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        to_data_port;
  logic        last_word;
  logic        shape_done;
  logic        busy_res;

  modport source (output valid, word, to_data_port, last_word, shape_done, busy_res,
                  input ready);
  modport sink   (input valid, word, to_data_port, last_word, shape_done, busy_res,
                  output ready);
endinterface

// File: rtl/core/lcr_fifo.sv
// two-entry queue of pixel and rectangle records
module lcr_fifo import lcr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  record_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output record_t pop_data_o,
  output logic    empty_o
);

  record_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/lcr_front.sv
// command decode, line and circle stepping, record build
module lcr_front import lcr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  lcr_in_if.sink  in_i,
  input  logic    q_full_i,
  output logic    q_push_o,
  output record_t q_data_o
);

  localparam int DW  = COORD_BITS + 1;
  localparam int EW  = COORD_BITS + 3;
  localparam int E2W = COORD_BITS + 4;
  localparam logic signed [ARC_ERR_W-1:0] ERR_ONE = 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ARC_W-1:0]      arc_t;
  typedef logic signed [ARC_ERR_W-1:0]  arc_err_t;

  typedef struct packed {
    coord_t                cur_x;
    coord_t                cur_y;
    coord_t                goal_x;
    coord_t                goal_y;
    logic signed [DW-1:0]  delta_x;
    logic signed [DW-1:0]  delta_y_neg;
    logic                  step_x_neg;
    logic                  step_y_neg;
    logic signed [EW-1:0]  err;
  } line_t;

  function automatic line_t load_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    line_t                l;
    logic signed [DW-1:0] ddx;
    logic signed [DW-1:0] ddy;
    ddx           = DW'(x1) - DW'(x0);
    ddy           = DW'(y1) - DW'(y0);
    l.cur_x       = x0;
    l.cur_y       = y0;
    l.goal_x      = x1;
    l.goal_y      = y1;
    l.delta_x     = (ddx > 0) ? ddx : -ddx;
    l.delta_y_neg = (ddy > 0) ? -ddy : ddy;
    l.step_x_neg  = !(x0 < x1);
    l.step_y_neg  = !(y0 < y1);
    l.err         = EW'(l.delta_x) + EW'(l.delta_y_neg);
    return l;
  endfunction

  // spans 0/1: rows cy+y, cy-y over cx+-x; spans 2/3: rows cy+x, cy-x over cx+-y
  function automatic line_t load_span(coord_t cx, coord_t cy, arc_t ax, arc_t ay,
                                      logic [SPAN_W-1:0] sidx);
    arc_t   p;
    arc_t   q;
    coord_t row;
    if (sidx < 2'd2) begin
      p = ax;
      q = ay;
    end else begin
      p = ay;
      q = ax;
    end
    if (sidx[0]) begin
      q = -q;
    end
    row = cy + coord_t'(q);
    return load_line(cx - coord_t'(p), row, cx + coord_t'(p), row);
  endfunction

  logic              active_q, active_d;
  logic              circle_q, circle_d;
  logic [SPAN_W-1:0] span_q, span_d;
  logic [31:0]       pen_q;
  line_t             line_q, line_d;
  coord_t            mid_x_q, mid_y_q;
  arc_t              arc_x_q, arc_x_d;
  arc_t              arc_y_q, arc_y_d;
  arc_err_t          arc_err_q, arc_err_d;

  line_t             adv_line;
  arc_t              adv_arc_x, adv_arc_y, ay_inc, ax_dec;
  arc_err_t          adv_arc_err;
  logic [SPAN_W-1:0] adv_span;
  logic              adv_done;
  logic signed [E2W-1:0] e2;
  logic              step_x, step_y;

  func_e             func;
  logic              fire;
  arc_t              rad_arc;
  line_t             line_load, circle_load;
  logic [7:0]        x_last, y_last;
  logic [15:0]       area;
  record_t           pix_rec, rect_rec;

  assign func      = func_e'(in_i.func);
  assign in_i.ready = !q_full_i;
  assign fire      = in_i.valid && in_i.ready;
  assign rad_arc   = arc_t'(in_i.radius);

  // next position of the shape after the pixel currently shown
  always_comb begin
    adv_line    = line_q;
    adv_arc_x   = arc_x_q;
    adv_arc_y   = arc_y_q;
    adv_arc_err = arc_err_q;
    adv_span    = span_q;
    adv_done    = 1'b0;
    ay_inc      = arc_y_q + arc_t'(1);
    ax_dec      = arc_x_q - arc_t'(1);
    e2          = E2W'(line_q.err) <<< 1;
    step_x      = (e2 >= E2W'(line_q.delta_y_neg));
    step_y      = (e2 <= E2W'(line_q.delta_x));
    if (line_q.cur_x == line_q.goal_x && line_q.cur_y == line_q.goal_y) begin
      if (!circle_q) begin
        adv_done = 1'b1;
      end else if (span_q != SPAN_LAST) begin
        adv_span = span_q + 1'b1;
        adv_line = load_span(mid_x_q, mid_y_q, arc_x_q, arc_y_q, adv_span);
      end else begin
        adv_span  = '0;
        adv_arc_y = ay_inc;
        if (arc_err_q < 0) begin
          adv_arc_err = arc_err_q + (arc_err_t'(ay_inc) <<< 1) + ERR_ONE;
        end else begin
          adv_arc_x   = ax_dec;
          adv_arc_err = arc_err_q + ((arc_err_t'(ay_inc) - arc_err_t'(ax_dec)) <<< 1)
                        + ERR_ONE;
        end
        if (adv_arc_x >= adv_arc_y) begin
          adv_line = load_span(mid_x_q, mid_y_q, adv_arc_x, adv_arc_y, '0);
        end else begin
          adv_done = 1'b1;
        end
      end
    end else begin
      adv_line.err = line_q.err + (step_x ? EW'(line_q.delta_y_neg) : '0)
                     + (step_y ? EW'(line_q.delta_x) : '0);
      if (step_x) begin
        adv_line.cur_x = line_q.cur_x + (line_q.step_x_neg ? coord_t'(-1) : coord_t'(1));
      end
      if (step_y) begin
        adv_line.cur_y = line_q.cur_y + (line_q.step_y_neg ? coord_t'(-1) : coord_t'(1));
      end
    end
  end

  assign line_load   = load_line(in_i.x_start, in_i.y_start, in_i.x_end, in_i.y_end);
  assign circle_load = load_span(in_i.x_start, in_i.y_start, rad_arc, '0, '0);

  // output records
  always_comb begin
    pix_rec.words[0] = window_word(OP_COL_WIN, line_q.cur_x[7:0], line_q.cur_x[7:0]);
    pix_rec.words[1] = window_word(OP_ROW_WIN, line_q.cur_y[7:0], line_q.cur_y[7:0]);
    pix_rec.words[2] = {OP_STREAM, STREAM_ONE};
    pix_rec.words[3] = pen_q;
    pix_rec.done     = adv_done;
    pix_rec.busy     = !adv_done;

    x_last            = in_i.x_start[7:0] + in_i.width - 8'd1;
    y_last            = in_i.y_start[7:0] + in_i.height - 8'd1;
    area              = 16'(in_i.width) * 16'(in_i.height);
    rect_rec.words[0] = window_word(OP_COL_WIN, in_i.x_start[7:0], x_last);
    rect_rec.words[1] = window_word(OP_ROW_WIN, in_i.y_start[7:0], y_last);
    rect_rec.words[2] = {OP_STREAM, 24'(area >> 1)};
    rect_rec.words[3] = in_i.color;
    rect_rec.done     = 1'b0;
    rect_rec.busy     = active_q;
  end

  assign q_push_o = fire && (func == FUNC_RECT || (func == FUNC_TICK && active_q));
  assign q_data_o = (func == FUNC_RECT) ? rect_rec : pix_rec;

  always_comb begin
    active_d  = active_q;
    circle_d  = circle_q;
    span_d    = span_q;
    line_d    = line_q;
    arc_x_d   = arc_x_q;
    arc_y_d   = arc_y_q;
    arc_err_d = arc_err_q;
    if (fire) begin
      case (func)
        FUNC_LINE: begin
          active_d = 1'b1;
          circle_d = 1'b0;
          span_d   = '0;
          line_d   = line_load;
        end
        FUNC_CIRCLE: begin
          active_d  = 1'b1;
          circle_d  = 1'b1;
          span_d    = '0;
          line_d    = circle_load;
          arc_x_d   = rad_arc;
          arc_y_d   = '0;
          arc_err_d = ERR_ONE - arc_err_t'(in_i.radius);
        end
        FUNC_TICK: begin
          if (active_q) begin
            active_d  = !adv_done;
            span_d    = adv_span;
            line_d    = adv_line;
            arc_x_d   = adv_arc_x;
            arc_y_d   = adv_arc_y;
            arc_err_d = adv_arc_err;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      circle_q <= 1'b0;
      span_q   <= '0;
    end else begin
      active_q <= active_d;
      circle_q <= circle_d;
      span_q   <= span_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q    <= line_d;
    arc_x_q   <= arc_x_d;
    arc_y_q   <= arc_y_d;
    arc_err_q <= arc_err_d;
    if (fire && (func == FUNC_LINE || func == FUNC_CIRCLE)) begin
      pen_q <= in_i.color;
    end
    if (fire && func == FUNC_CIRCLE) begin
      mid_x_q <= in_i.x_start;
      mid_y_q <= in_i.y_start;
    end
  end

endmodule

// File: rtl/core/lcr_back.sv
// word serialiser: sends each record as four transfers
module lcr_back import lcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  record_t    q_data_i,
  output logic       q_pop_o,
  lcr_out_if.source  out_o
);

  record_t          rec_q;
  logic             valid_q, valid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             xfer, last_xfer;

  assign xfer      = out_o.valid && out_o.ready;
  assign last_xfer = xfer && (idx_q == LAST_IDX);
  assign q_pop_o   = !q_empty_i && (!valid_q || last_xfer);

  assign out_o.valid        = valid_q;
  assign out_o.word         = rec_q.words[idx_q];
  assign out_o.to_data_port = (idx_q == LAST_IDX);
  assign out_o.last_word    = (idx_q == LAST_IDX);
  assign out_o.shape_done   = rec_q.done;
  assign out_o.busy_res     = rec_q.busy;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (last_xfer) begin
      valid_d = 1'b0;
      idx_d   = '0;
    end else if (xfer) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q <= q_data_i;
    end
  end

endmodule

// File: rtl/core/line_circle_rect_rasterizer.sv
// Shape rasterizer: turns line, filled-circle and rectangle commands into display-controller
// command words (column window, row window, stream count, colour). A line or circle command
// loads the shape; each following tick emits the next pixel as four words until the shape
// is done. A rectangle is emitted at once and leaves a shape in progress alone. Commands are
// taken one per cycle into a two-record queue; results leave one word per cycle while the
// output is ready, so every tick or rectangle occupies the output port for four words, and
// the input stalls only when both queue entries wait behind the word in flight.
module line_circle_rect_rasterizer import lcr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcr_in_if.sink    in_i,
  lcr_out_if.source out_o
);

  logic    q_push, q_full, q_pop, q_empty;
  record_t q_push_data, q_pop_data;

  lcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_push_data)
  );

  lcr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  lcr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_pop_data),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// File: rtl/core/lcr_checker.sv
// port-level checks on the output word stream
module lcr_checker import lcr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_word_i,
  input logic        out_to_data_port_i,
  input logic        out_last_word_i,
  input logic        out_shape_done_i,
  input logic        out_busy_res_i
);

  logic xfer;
  assign xfer = out_valid_i && out_ready_i;

  // the colour word is always the closing word of a group
  a_data_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_to_data_port_i == out_last_word_i))
    else $error("data port word and last word disagree");

  a_cmd_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_to_data_port_i) |->
      (out_word_i[31:24] == OP_COL_WIN || out_word_i[31:24] == OP_ROW_WIN ||
       out_word_i[31:24] == OP_STREAM))
    else $error("command word carries an unknown opcode");

  a_group_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !out_last_word_i) |=> out_valid_i)
    else $error("word group broken off before its last word");

  a_col_then_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && out_word_i[31:24] == OP_COL_WIN && !out_to_data_port_i) |=>
      (out_word_i[31:24] == OP_ROW_WIN))
    else $error("row window does not follow column window");

  a_flags_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !out_last_word_i) |=> ($stable(out_shape_done_i) && $stable(out_busy_res_i)))
    else $error("status flags change inside a word group");

endmodule

bind line_circle_rect_rasterizer lcr_checker u_lcr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_word_i         (out_o.word),
  .out_to_data_port_i (out_o.to_data_port),
  .out_last_word_i    (out_o.last_word),
  .out_shape_done_i   (out_o.shape_done),
  .out_busy_res_i     (out_o.busy_res)
);
